// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of the color converter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== sv/ycc_pkg.sv =====
// Package of the color converter: widths, the stage enable struct and the
// fixed point coefficient and bias tables. Depends on nothing.
`timescale 1ns / 1ps

package ycc_pkg;

  localparam int PIX_W  = 8;
  localparam int OP_W   = 9;    // centered chroma or plain 8-bit component, signed
  localparam int COEF_W = 18;   // signed coefficient with 16 fractional bits
  localparam int FRAC_W = 16;
  localparam int SUM_W  = OP_W + COEF_W;  // product and sum width
  localparam int LANES  = 3;
  localparam int TAPS   = 3;

  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Direction codes carried in the kind field.
  localparam logic KIND_YCC2RGB = 1'b0;
  localparam logic KIND_RGB2YCC = 1'b1;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Coefficients indexed by kind, output lane and input tap.
  localparam coef_t COEF [2][LANES][TAPS] = '{
    '{ '{ 18'sd65536,   18'sd0,      18'sd91881 },
       '{ 18'sd65536,  -18'sd22553, -18'sd46802 },
       '{ 18'sd65536,   18'sd116130, 18'sd0     } },
    '{ '{ 18'sd19595,   18'sd38470,  18'sd7471  },
       '{-18'sd11058,  -18'sd21710,  18'sd32768 },
       '{ 18'sd32768,  -18'sd27439, -18'sd5329  } }
  };

  // Rounding and chroma offsets at 16 fractional bits.
  localparam sum_t BIAS [2][LANES] = '{
    '{ 27'sd32768, 27'sd32768,   27'sd32768   },
    '{ 27'sd32768, 27'sd8421376, 27'sd8421376 }
  };

endpackage

// ===== sv/ycc_in_if.sv =====
// Input channel of the color converter: one pixel word with its direction.
// Depends on nothing.
`timescale 1ns / 1ps

interface ycc_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_a;
  logic [7:0] in_b;
  logic [7:0] in_c;

  modport source (output valid, output kind, output in_a, output in_b, output in_c,
                  input ready);
  modport sink   (input valid, input kind, input in_a, input in_b, input in_c,
                  output ready);
endinterface

// ===== sv/ycc_out_if.sv =====
// Result channel of the color converter: one converted pixel word.
// Depends on nothing.
`timescale 1ns / 1ps

interface ycc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_a;
  logic [7:0] out_b;
  logic [7:0] out_c;

  modport source (output valid, output out_a, output out_b, output out_c,
                  input ready);
  modport sink   (input valid, input out_a, input out_b, input out_c,
                  output ready);
endinterface

// ===== sv/ycc_lane.sv =====
// One output component of the converter: multiply, sum with bias, clamp.
// Depends on ycc_pkg.
`timescale 1ns / 1ps

module ycc_lane (
  input  logic                         clk,
  input  ycc_pkg::stage_en_t           en,
  input  ycc_pkg::op_t                 op_a,
  input  ycc_pkg::op_t                 op_b,
  input  ycc_pkg::op_t                 op_c,
  input  ycc_pkg::coef_t               coef_a,
  input  ycc_pkg::coef_t               coef_b,
  input  ycc_pkg::coef_t               coef_c,
  input  ycc_pkg::sum_t                bias,
  output logic [ycc_pkg::PIX_W-1:0]    res
);

  ycc_pkg::sum_t prod_a_r, prod_b_r, prod_c_r;
  ycc_pkg::sum_t prod_a_nxt, prod_b_nxt, prod_c_nxt;
  ycc_pkg::sum_t sum_r, sum_nxt;
  logic [ycc_pkg::PIX_W-1:0] res_r, res_nxt;

  always_comb begin
    prod_a_nxt = op_a * coef_a;
    prod_b_nxt = op_b * coef_b;
    prod_c_nxt = op_c * coef_c;
    sum_nxt    = prod_a_r + prod_b_r + prod_c_r + bias;
    // Floor to an integer, then clamp negative sums to 0 and large ones to 255.
    if (sum_r[ycc_pkg::SUM_W-1]) begin
      res_nxt = '0;
    end else if (|sum_r[ycc_pkg::SUM_W-2:ycc_pkg::FRAC_W+ycc_pkg::PIX_W]) begin
      res_nxt = '1;
    end else begin
      res_nxt = sum_r[ycc_pkg::FRAC_W+ycc_pkg::PIX_W-1:ycc_pkg::FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
      prod_c_r <= prod_c_nxt;
    end
    if (en.s3) begin
      sum_r <= sum_nxt;
    end
    if (en.s4) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== sv/ycbcr_rgb_color_convert_top.sv =====
// Full-range BT.601 (JFIF) color converter between Y'CbCr and 8-bit RGB.
// Depends on ycc_pkg, ycc_in_if, ycc_out_if and ycc_lane.
//
// Use: each word on in_ch carries a kind bit and three 8-bit components.
// Kind 0 takes Y, Cb, Cr and returns R, G, B; kind 1 takes R, G, B and
// returns Y, Cb, Cr. Every accepted word yields exactly one word on out_ch,
// in order. Words move on a clock edge where valid and ready are both high.
//
// A word accepted on in_ch passes through four registered stages and
// raises out_ch.valid once it reaches the output register. An operand
// stage centers chroma, a multiply stage forms the nine products, a sum stage
// adds them with the rounding and offset constant, and a clamp stage floors
// and limits each component to 0..255 into the output register.
// Throughput is one pixel per cycle while out_ch.ready is high; each stage
// holds one word and passes it on as soon as the stage after it is free.
//
// Reset (rst_n low at a clock edge) empties all four stages; nothing else
// carries state. When the receiver holds out_ch.ready low, the output word
// stays stable and the earlier stages keep filling until all four are full,
// after which in_ch.ready drops. No word is lost or repeated by a stall.
`timescale 1ns / 1ps

module ycbcr_rgb_color_convert_top (
  input  logic         clk,
  input  logic         rst_n,
  ycc_in_if.sink       in_ch,
  ycc_out_if.source    out_ch
);

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;

  // A stage loads when it is empty or when the stage after it loads.
  ycc_pkg::stage_en_t en;

  // Operand stage payload.
  ycc_pkg::op_t op_a_r, op_b_r, op_c_r;
  ycc_pkg::op_t op_a_nxt, op_b_nxt, op_c_nxt;
  logic kind1_r, kind2_r;

  logic [ycc_pkg::PIX_W-1:0] res [ycc_pkg::LANES];

  always_comb begin
    en.s4 = !v4_r || out_ch.ready;
    en.s3 = !v3_r || en.s4;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;

    v1_nxt = en.s1 ? in_ch.valid : v1_r;
    v2_nxt = en.s2 ? v1_r : v2_r;
    v3_nxt = en.s3 ? v2_r : v3_r;
    v4_nxt = en.s4 ? v3_r : v4_r;

    // Y'CbCr input: luma stays unsigned, chroma is centered by flipping its
    // top bit and sign extending. RGB input: all three stay unsigned.
    if (in_ch.kind == ycc_pkg::KIND_YCC2RGB) begin
      op_a_nxt = {1'b0, in_ch.in_a};
      op_b_nxt = {~in_ch.in_b[7], ~in_ch.in_b[7], in_ch.in_b[6:0]};
      op_c_nxt = {~in_ch.in_c[7], ~in_ch.in_c[7], in_ch.in_c[6:0]};
    end else begin
      op_a_nxt = {1'b0, in_ch.in_a};
      op_b_nxt = {1'b0, in_ch.in_b};
      op_c_nxt = {1'b0, in_ch.in_c};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      op_a_r  <= op_a_nxt;
      op_b_r  <= op_b_nxt;
      op_c_r  <= op_c_nxt;
      kind1_r <= in_ch.kind;
    end
    if (en.s2) begin
      kind2_r <= kind1_r;
    end
  end

  // One lane per output component; coefficients follow the operand stage's
  // kind, the bias follows the multiply stage's kind.
  for (genvar l = 0; l < ycc_pkg::LANES; l++) begin : g_lane
    ycc_lane u_lane (
      .clk    (clk),
      .en     (en),
      .op_a   (op_a_r),
      .op_b   (op_b_r),
      .op_c   (op_c_r),
      .coef_a (ycc_pkg::COEF[kind1_r][l][0]),
      .coef_b (ycc_pkg::COEF[kind1_r][l][1]),
      .coef_c (ycc_pkg::COEF[kind1_r][l][2]),
      .bias   (ycc_pkg::BIAS[kind2_r][l]),
      .res    (res[l])
    );
  end

  assign in_ch.ready  = en.s1;
  assign out_ch.valid = v4_r;
  assign out_ch.out_a = res[0];
  assign out_ch.out_b = res[1];
  assign out_ch.out_c = res[2];

endmodule

// ===== sv/ycc_checker.sv =====
// Port level checks of the color converter and their bind to the top level.
// Depends on assert_macros.svh and ycbcr_rgb_color_convert_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ycc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_a,
  input logic [7:0] out_b,
  input logic [7:0] out_c
);

  // Words accepted but not yet delivered; the pipeline holds at most four.
  logic [2:0]  cnt_r, cnt_nxt;
  logic        in_acc, out_acc;
  logic        out_stall;
  logic [23:0] out_word;

  always_comb begin
    in_acc    = in_valid && in_ready;
    out_acc   = out_valid && out_ready;
    out_stall = out_valid && !out_ready;
    out_word  = {out_a, out_b, out_c};
    cnt_nxt   = cnt_r + {2'b00, in_acc} - {2'b00, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid, "stalled output word dropped")
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(out_word), "stalled word changed")
  `ASSERT_ALWAYS(a_no_invent, clk, rst_n, !out_valid || cnt_r != 3'd0, "unexpected output word")
  `ASSERT_ALWAYS(a_depth, clk, rst_n, cnt_r <= 3'd4, "more than four words in flight")
  `ASSERT_ALWAYS(a_ready_empty, clk, rst_n, out_valid || in_ready, "input stalled on empty output")

endmodule

bind ycbcr_rgb_color_convert_top ycc_checker u_ycc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_a     (out_ch.out_a),
  .out_b     (out_ch.out_b),
  .out_c     (out_ch.out_c)
);
